// ----- rtl/core/nks_pkg.sv -----
// ----------------------------------------------------------------------------
// nks_pkg
// Shared constants, the command word passed from the front to the back and
// the state type of the back-end sequencer.
// ----------------------------------------------------------------------------
package nks_pkg;

    localparam int MAX_KEPT_DEF = 32;
    localparam int KEY_BITS_DEF = 16;
    localparam int KEY_FIELD_W  = 16;
    localparam int DIST_W       = 18;
    localparam int RANK_W       = 5;
    localparam int Q_DEPTH      = 2;

    localparam logic [DIST_W-1:0] RADIUS_RESET = '1;

    // One classified candidate on its way to the sorted list.
    typedef struct packed {
        logic [KEY_FIELD_W-1:0] key;
        logic [DIST_W-1:0]      how_far;
        logic                   ins;
        logic                   last;
    } cmd_t;

    typedef enum logic {
        BK_RUN,
        BK_READ
    } back_state_t;

endpackage

// ----- rtl/core/nks_front.sv -----
// ----------------------------------------------------------------------------
// nks_front
// Holds the radius register, takes candidates and turns each one into a
// command for the back end, dropping those that need no work at all.
// ----------------------------------------------------------------------------
module nks_front #(
    parameter int KEY_BITS = nks_pkg::KEY_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [nks_pkg::KEY_FIELD_W-1:0]  entry_key,
    input  logic [nks_pkg::DIST_W-1:0]       distance,
    input  logic                             last_candidate,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [nks_pkg::DIST_W-1:0]       cfg_data,
    output logic                             push_valid,
    input  logic                             push_ready,
    output nks_pkg::cmd_t                    push_cmd
);

    localparam int KF_W  = nks_pkg::KEY_FIELD_W;
    localparam int KEY_W = (KEY_BITS < KF_W) ? KEY_BITS : KF_W;

    logic [nks_pkg::DIST_W-1:0] radius_reg;
    logic [nks_pkg::DIST_W-1:0] radius_next;
    logic                       in_range;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        radius_next = radius_reg;
        if (cfg_valid)
        begin
            radius_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= nks_pkg::RADIUS_RESET;
        end
        else
        begin
            radius_reg <= radius_next;
        end
    end

    assign in_range = (distance <= radius_reg);

    // A word that is out of range and does not close the run is taken and
    // simply forgotten.
    assign in_ready         = push_ready;
    assign push_valid       = in_valid && (in_range || last_candidate);
    assign push_cmd.key     = KF_W'(entry_key[KEY_W-1:0]);
    assign push_cmd.how_far = distance;
    assign push_cmd.ins     = in_range;
    assign push_cmd.last    = last_candidate;

endmodule

// ----- rtl/core/nks_queue.sv -----
// ----------------------------------------------------------------------------
// nks_queue
// Short first-in first-out queue of commands between the front and the back.
// ----------------------------------------------------------------------------
module nks_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  nks_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output nks_pkg::cmd_t pop_cmd
);

    localparam int DEPTH = nks_pkg::Q_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    nks_pkg::cmd_t    q_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (fill_reg != CNT_W'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = q_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/core/nks_back.sv -----
// ----------------------------------------------------------------------------
// nks_back
// Sorted row of cells with a registered insert and the readout sequencer that
// shifts the row out nearest first through the output register.
// ----------------------------------------------------------------------------
module nks_back #(
    parameter int MAX_KEPT = nks_pkg::MAX_KEPT_DEF,
    parameter int KEY_BITS = nks_pkg::KEY_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_ready,
    input  nks_pkg::cmd_t                    cmd,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [nks_pkg::RANK_W-1:0]       rank,
    output logic [nks_pkg::KEY_FIELD_W-1:0]  kept_key,
    output logic [nks_pkg::DIST_W-1:0]       kept_distance,
    output logic                             list_empty,
    output logic                             last_of_run
);

    localparam int KF_W  = nks_pkg::KEY_FIELD_W;
    localparam int DW    = nks_pkg::DIST_W;
    localparam int RW    = nks_pkg::RANK_W;
    localparam int KEY_W = (KEY_BITS < KF_W) ? KEY_BITS : KF_W;
    localparam int CNT_W = $clog2(MAX_KEPT + 1);

    nks_pkg::back_state_t state_reg;
    nks_pkg::back_state_t state_next;

    logic [KEY_W-1:0] key_reg   [MAX_KEPT];
    logic [KEY_W-1:0] key_next  [MAX_KEPT];
    logic [DW-1:0]    dist_reg  [MAX_KEPT];
    logic [DW-1:0]    dist_next [MAX_KEPT];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [RW-1:0]    rank_reg;
    logic [RW-1:0]    rank_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [RW-1:0]    out_rank_reg;
    logic [RW-1:0]    out_rank_next;
    logic [KF_W-1:0]  out_key_reg;
    logic [KF_W-1:0]  out_key_next;
    logic [DW-1:0]    out_dist_reg;
    logic [DW-1:0]    out_dist_next;
    logic             out_empty_reg;
    logic             out_empty_next;
    logic             out_last_reg;
    logic             out_last_next;

    logic [MAX_KEPT-1:0] le;
    logic [KEY_W-1:0]    new_key;
    logic                slot_free;
    logic                sorted_ok;

    assign new_key   = cmd.key[KEY_W-1:0];
    assign slot_free = !out_valid_reg || out_ready;

    // Each occupied cell holding a distance no greater than the newcomer's
    // stays put; the list is sorted, so these cells form a prefix.
    always_comb
    begin
        for (int i = 0; i < MAX_KEPT; i++)
        begin
            le[i] = (CNT_W'(i) < count_reg) && (dist_reg[i] <= cmd.how_far);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rank_next      = rank_reg;
        key_next       = key_reg;
        dist_next      = dist_reg;
        cmd_ready      = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        out_rank_next  = out_rank_reg;
        out_key_next   = out_key_reg;
        out_dist_next  = out_dist_reg;
        out_empty_next = out_empty_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            nks_pkg::BK_RUN:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    if (cmd.ins && !le[MAX_KEPT-1])
                    begin
                        if (!le[0])
                        begin
                            key_next[0]  = new_key;
                            dist_next[0] = cmd.how_far;
                        end
                        for (int i = 1; i < MAX_KEPT; i++)
                        begin
                            if (!le[i])
                            begin
                                key_next[i]  = le[i-1] ? new_key     : key_reg[i-1];
                                dist_next[i] = le[i-1] ? cmd.how_far : dist_reg[i-1];
                            end
                        end
                        if (count_reg != CNT_W'(MAX_KEPT))
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    if (cmd.last)
                    begin
                        state_next = nks_pkg::BK_READ;
                        rank_next  = '0;
                    end
                end
            end
            nks_pkg::BK_READ:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (count_reg == '0)
                    begin
                        out_rank_next  = '0;
                        out_key_next   = '0;
                        out_dist_next  = '0;
                        out_empty_next = 1'b1;
                        out_last_next  = 1'b1;
                        state_next     = nks_pkg::BK_RUN;
                    end
                    else
                    begin
                        out_rank_next  = rank_reg;
                        out_key_next   = KF_W'(key_reg[0]);
                        out_dist_next  = dist_reg[0];
                        out_empty_next = 1'b0;
                        out_last_next  = (count_reg == CNT_W'(1));
                        for (int i = 0; i < MAX_KEPT - 1; i++)
                        begin
                            key_next[i]  = key_reg[i+1];
                            dist_next[i] = dist_reg[i+1];
                        end
                        count_next = count_reg - 1'b1;
                        rank_next  = rank_reg + 1'b1;
                        if (count_reg == CNT_W'(1))
                        begin
                            state_next = nks_pkg::BK_RUN;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nks_pkg::BK_RUN;
            count_reg     <= '0;
            rank_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rank_reg      <= rank_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        dist_reg      <= dist_next;
        out_rank_reg  <= out_rank_next;
        out_key_reg   <= out_key_next;
        out_dist_reg  <= out_dist_next;
        out_empty_reg <= out_empty_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid     = out_valid_reg;
    assign rank          = out_rank_reg;
    assign kept_key      = out_key_reg;
    assign kept_distance = out_dist_reg;
    assign list_empty    = out_empty_reg;
    assign last_of_run   = out_last_reg;

    always_comb
    begin
        sorted_ok = 1'b1;
        for (int i = 1; i < MAX_KEPT; i++)
        begin
            if ((CNT_W'(i) < count_reg) && (dist_reg[i-1] > dist_reg[i]))
            begin
                sorted_ok = 1'b0;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_KEPT))
        else $error("kept count exceeds the list length");

    a_list_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        sorted_ok)
        else $error("kept entries are out of distance order");

    a_read_holds_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nks_pkg::BK_READ) |-> !cmd_ready)
        else $error("command taken during readout");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_empty_reg) |-> (out_last_reg && (out_dist_reg == '0)))
        else $error("empty result not flagged last or not zeroed");

    a_read_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nks_pkg::BK_READ && slot_free && count_reg == CNT_W'(1))
        |=> (state_reg == nks_pkg::BK_RUN && count_reg == '0))
        else $error("readout did not end after its final word");

endmodule

// ----- rtl/core/nearest_k_selector.sv -----
// ----------------------------------------------------------------------------
// nearest_k_selector
// Keeps the MAX_KEPT nearest candidates of a run and reads them out nearest
// first when the run closes.
// ----------------------------------------------------------------------------
// Candidates arrive as words on the input channel, one per cycle while the
// two-entry command queue has room. A candidate farther than the radius
// register is dropped at the front unless it closes the run; every other one
// is inserted into the row of sorted cells unless the row is full and holds
// nothing farther, so a run of ordinary candidates streams at one word per
// cycle. A word with last_candidate set is inserted first if it qualifies
// and then starts the readout: the row is shifted out through the output
// register, one result word per cycle while the consumer keeps out_ready
// high, giving n words for n kept entries or a single word flagged list_empty
// when nothing was kept. During that readout the back end takes no commands;
// the front still accepts up to two further words into the queue. Entries of
// equal distance leave in arrival order. The radius register is written
// through the cfg channel and should only be changed while the block is idle.
// ----------------------------------------------------------------------------
module nearest_k_selector #(
    parameter int MAX_KEPT = nks_pkg::MAX_KEPT_DEF,
    parameter int KEY_BITS = nks_pkg::KEY_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [nks_pkg::DIST_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [nks_pkg::KEY_FIELD_W-1:0]  entry_key,
    input  logic [nks_pkg::DIST_W-1:0]       distance,
    input  logic                             last_candidate,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [nks_pkg::RANK_W-1:0]       rank,
    output logic [nks_pkg::KEY_FIELD_W-1:0]  kept_key,
    output logic [nks_pkg::DIST_W-1:0]       kept_distance,
    output logic                             list_empty,
    output logic                             last_of_run
);

    // Commands from the front into the queue.
    logic          push_valid;
    logic          push_ready;
    nks_pkg::cmd_t push_cmd;

    // Commands from the queue into the sorted row.
    logic          pop_valid;
    logic          pop_ready;
    nks_pkg::cmd_t pop_cmd;

    // The front owns the radius register and decides, per word, whether the
    // back end has anything to do with it.
    nks_front #(
        .KEY_BITS (KEY_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .entry_key      (entry_key),
        .distance       (distance),
        .last_candidate (last_candidate),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_cmd       (push_cmd)
    );

    // The queue lets the front keep accepting while a readout is under way.
    nks_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // The back end holds the sorted row and drives the result channel from
    // its own output register.
    nks_back #(
        .MAX_KEPT (MAX_KEPT),
        .KEY_BITS (KEY_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (pop_valid),
        .cmd_ready     (pop_ready),
        .cmd           (pop_cmd),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .rank          (rank),
        .kept_key      (kept_key),
        .kept_distance (kept_distance),
        .list_empty    (list_empty),
        .last_of_run   (last_of_run)
    );

endmodule
